[hdl/ensf_pkg.sv]
// ----------------------------------------------------------------------------
// Speckle filter package
// Shared sizes, register indexes, line memory word layout and helpers for the
// equal-neighbour speckle filter.
// ----------------------------------------------------------------------------
package ensf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_SIZE   = 3;

  localparam int PIX_W     = 8;
  localparam int CNT_W     = 4;
  localparam int THR_W     = 4;
  localparam int SIZE_W    = 11;
  localparam int TOTAL_W   = 20;
  localparam int CFG_IDX_W = 2;
  localparam int WIN_TAPS  = 9;

  localparam int IN_TDATA_W  = ((PIX_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((PIX_W + TOTAL_W + 7) / 8) * 8;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int LW_W   = $clog2(MAX_WIDTH + 1);
  localparam int LH_W   = $clog2(MAX_HEIGHT + 1);
  localparam int OROW_W = $clog2(MAX_HEIGHT);
  // The input row runs two rows past the frame while the frame drains.
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 3);

  localparam int THR_RESET    = 2;
  localparam int WIDTH_RESET  = 1024;
  localparam int HEIGHT_RESET = 1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_WIDTH     = 2'd1,
    CFG_HEIGHT    = 2'd2
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [CNT_W-1:0] count_t;

  // One column of the two rows above the current input position.
  typedef struct packed {
    pixel_t pix_up1;
    pixel_t pix_up2;
    count_t cnt_up1;
    count_t cnt_up2;
  } line_word_t;

  // Frame dimensions below the minimum or above the maximum are forced into range.
  function automatic int unsigned clamp_size(input logic [SIZE_W-1:0] size,
                                             input int unsigned limit);
    int unsigned v;
    v = 32'(size);
    if (v < MIN_SIZE) begin
      return MIN_SIZE;
    end
    if (v > limit) begin
      return limit;
    end
    return v;
  endfunction

endpackage

[hdl/equal_neighbor_speckle_filter.sv]
// ----------------------------------------------------------------------------
// Equal-neighbour speckle filter
// One 8-bit frame enters in raster order, one pixel per transaction, and the
// filter takes one transaction in every clock cycle as long as the result side
// keeps up: each pixel passes an input register, one pass of window logic and
// a result register. Every interior pixel is given the number of its eight
// neighbours that equal it; an interior pixel whose number is at or below the
// threshold is replaced by the first pixel of its 3x3 window, in raster order,
// whose number is above it (already filtered values above and to the left,
// original values elsewhere). Border pixels pass unchanged. Each result
// appears two rows plus two pixels of input after its own pixel, so once a
// frame is complete the source sends 2 * width + 2 further transactions (flush
// set, or any pixel) to drain it; the last result carries tlast and the
// frame's replacement count. A flush before a frame is complete is dropped.
// Frame size is taken from the registers when the first pixel of a frame
// arrives. Two line memories of MAX_WIDTH words hold the two rows above the
// input and the filtered row above the output; no clearing pass is needed
// after reset.
// ----------------------------------------------------------------------------
module equal_neighbor_speckle_filter
  import ensf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // Pixel input
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] pixel_in
  input  logic                   s_axis_tuser,   // [0] flush
  // Filtered output
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] pixel_out, [27:8] replaced_total
  output logic                   m_axis_tuser,   // [0] was_replaced
  output logic                   m_axis_tlast,   // frame_last
  // Register writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [SIZE_W-1:0]      cfg_data
);

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; an unknown index is
  // simply ignored.
  // --------------------------------------------------------------------------
  logic [THR_W-1:0]  neighbor_threshold;
  logic [SIZE_W-1:0] frame_width;
  logic [SIZE_W-1:0] frame_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      neighbor_threshold <= THR_W'(THR_RESET);
      frame_width        <= SIZE_W'(WIDTH_RESET);
      frame_height       <= SIZE_W'(HEIGHT_RESET);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_THRESHOLD: neighbor_threshold <= cfg_data[THR_W-1:0];
        CFG_WIDTH:     frame_width        <= cfg_data;
        CFG_HEIGHT:    frame_height       <= cfg_data;
        default:       ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register. It takes a new transaction whenever it is empty or its
  // item is being processed, so it holds off new ones while a result waits.
  // --------------------------------------------------------------------------
  logic   in_held;
  pixel_t in_pixel;
  logic   in_flush;
  logic   proc;

  assign proc          = in_held && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_held || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_held <= 1'b1;
    end else if (proc) begin
      in_held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_pixel <= s_axis_tdata[PIX_W-1:0];
      in_flush <= s_axis_tuser;
    end
  end

  // --------------------------------------------------------------------------
  // Stream position. ic/ir is the position of the item being processed,
  // oc/orow the position of the result it produces.
  // --------------------------------------------------------------------------
  logic [COL_W-1:0]   ic;
  logic [ROW_W-1:0]   ir;
  logic [COL_W-1:0]   oc;
  logic [OROW_W-1:0]  orow;
  logic [LW_W-1:0]    live_w;
  logic [LH_W-1:0]    live_h;
  logic [COL_W-1:0]   prev_col;
  logic [TOTAL_W-1:0] replaced_count;

  logic               at_start;
  logic               in_frame;
  logic               adv;
  logic               out_due;
  logic               emit;
  logic               q_last;
  logic               frame_done;
  logic [LW_W-1:0]    ic_inc;
  logic               col_wrap;
  logic [COL_W-1:0]   ic_next;
  logic [ROW_W-1:0]   ir_next;
  logic [COL_W-1:0]   rd_addr;

  assign at_start = (ir == '0) && (ic == '0);
  assign in_frame = ir < ROW_W'(live_h);

  // A flush that arrives while pixels of the frame are still due does
  // nothing; once the frame is complete every item moves the drain along.
  assign adv = proc && !(in_flush && in_frame);

  // The first result is due at input position 2 * width + 2.
  assign out_due = (ir > ROW_W'(2)) || ((ir == ROW_W'(2)) && (ic >= COL_W'(2)));
  assign emit    = adv && out_due;

  assign q_last     = (LH_W'(orow) == live_h - LH_W'(1)) && (LW_W'(oc) == live_w - LW_W'(1));
  assign frame_done = emit && q_last;

  assign ic_inc   = LW_W'(ic) + LW_W'(1);
  assign col_wrap = ic_inc >= live_w;

  always_comb begin
    if (frame_done) begin
      ic_next = '0;
      ir_next = '0;
    end else if (col_wrap) begin
      ic_next = '0;
      ir_next = ir + ROW_W'(1);
    end else begin
      ic_next = ic_inc[COL_W-1:0];
      ir_next = ir;
    end
  end

  // The line memories are read every cycle at the column of the item that
  // will be processed next, so their read registers always hold its column.
  assign rd_addr = adv ? ic_next : ic;

  always_ff @(posedge clk) begin
    if (rst) begin
      ic     <= '0;
      ir     <= '0;
      live_w <= LW_W'(clamp_size(SIZE_W'(WIDTH_RESET), MAX_WIDTH));
      live_h <= LH_W'(clamp_size(SIZE_W'(HEIGHT_RESET), MAX_HEIGHT));
    end else if (adv) begin
      ic <= ic_next;
      ir <= ir_next;
      if (at_start) begin
        live_w <= LW_W'(clamp_size(frame_width, MAX_WIDTH));
        live_h <= LH_W'(clamp_size(frame_height, MAX_HEIGHT));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oc   <= '0;
      orow <= '0;
    end else if (emit) begin
      if (frame_done) begin
        oc   <= '0;
        orow <= '0;
      end else if (LW_W'(oc) + LW_W'(1) >= live_w) begin
        oc   <= '0;
        orow <= orow + OROW_W'(1);
      end else begin
        oc <= oc + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prev_col <= ic;
    end
  end

  // --------------------------------------------------------------------------
  // Line memories. The original line memory keeps, per column, the pixels
  // and neighbour counts of the two rows above; the output line memory keeps
  // the filtered row above the result.
  // --------------------------------------------------------------------------
  line_word_t line_rd;
  line_word_t line_wr;
  pixel_t     y_rd;
  pixel_t     y_new;
  count_t     k0;

  assign line_wr = '{pix_up1: in_pixel, pix_up2: line_rd.pix_up1,
                     cnt_up1: k0,       cnt_up2: line_rd.cnt_up1};

  ensf_ram #(
    .WIDTH ($bits(line_word_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (adv),
    .wr_addr (ic),
    .wr_data (line_wr),
    .rd_addr (rd_addr),
    .rd_data (line_rd)
  );

  // A result is stored one column behind the input, so that reading at the
  // input column returns the filtered pixel up and to the right of the next
  // result, the newest of the three filtered pixels its window needs.
  ensf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_out_ram (
    .clk     (clk),
    .wr_en   (emit),
    .wr_addr (prev_col),
    .wr_data (y_new),
    .rd_addr (rd_addr),
    .rd_data (y_rd)
  );

  // --------------------------------------------------------------------------
  // Window taps. With the stream at position p, the count centre sits at
  // p - width - 1 and the result at p - 2 * width - 2. Taps that cross a row
  // end only feed border positions, whose values are never used.
  // --------------------------------------------------------------------------
  pixel_t x0_d1, x0_d2;
  pixel_t r1_d1, r1_d2, r1_d3;
  pixel_t r2_d1, r2_d2;
  count_t k0_d1, k0_d2;
  count_t k1_d1, k1_d2;
  count_t k2_d1, k2_d2;
  pixel_t y_d1, y_d2;
  pixel_t y_prev;

  always_ff @(posedge clk) begin
    if (adv) begin
      x0_d1 <= in_pixel;
      x0_d2 <= x0_d1;
      r1_d1 <= line_rd.pix_up1;
      r1_d2 <= r1_d1;
      r1_d3 <= r1_d2;
      r2_d1 <= line_rd.pix_up2;
      r2_d2 <= r2_d1;
      k0_d1 <= k0;
      k0_d2 <= k0_d1;
      k1_d1 <= line_rd.cnt_up1;
      k1_d2 <= k1_d1;
      k2_d1 <= line_rd.cnt_up2;
      k2_d2 <= k2_d1;
      y_d1  <= y_rd;
      y_d2  <= y_d1;
    end
    if (emit) begin
      y_prev <= y_new;
    end
  end

  // Neighbour count for the centre one row up and one column left. Only an
  // interior centre gets a count; everything else counts as zero.
  logic [7:0] eq;
  logic       k_interior;

  assign eq = {r2_d2 == r1_d1, r2_d1 == r1_d1, line_rd.pix_up2 == r1_d1,
               r1_d2 == r1_d1, line_rd.pix_up1 == r1_d1,
               x0_d2 == r1_d1, x0_d1 == r1_d1, in_pixel == r1_d1};

  assign k_interior = (ic >= COL_W'(2)) && (ir >= ROW_W'(2)) && in_frame;
  assign k0         = k_interior ? CNT_W'($countones(eq)) : '0;

  // --------------------------------------------------------------------------
  // Replacement. The window is scanned in raster order; positions before the
  // result take filtered values, the rest original ones.
  // --------------------------------------------------------------------------
  count_t             cand_cnt [WIN_TAPS];
  pixel_t             cand_pix [WIN_TAPS];
  pixel_t             pick_pix;
  logic               pick_found;
  logic               q_interior;
  logic               replace;
  logic [TOTAL_W-1:0] count_plus;

  always_comb begin
    cand_cnt[0] = k2_d2;            cand_pix[0] = y_d2;
    cand_cnt[1] = k2_d1;            cand_pix[1] = y_d1;
    cand_cnt[2] = line_rd.cnt_up2;  cand_pix[2] = y_rd;
    cand_cnt[3] = k1_d2;            cand_pix[3] = y_prev;
    cand_cnt[4] = k1_d1;            cand_pix[4] = r2_d2;
    cand_cnt[5] = line_rd.cnt_up1;  cand_pix[5] = r2_d1;
    cand_cnt[6] = k0_d2;            cand_pix[6] = r1_d3;
    cand_cnt[7] = k0_d1;            cand_pix[7] = r1_d2;
    cand_cnt[8] = k0;               cand_pix[8] = r1_d1;
  end

  // Later taps are overridden by earlier ones, so the first stable pixel wins.
  always_comb begin
    pick_pix   = r2_d2;
    pick_found = 1'b0;
    for (int i = WIN_TAPS - 1; i >= 0; i--) begin
      if (cand_cnt[i] > neighbor_threshold) begin
        pick_pix   = cand_pix[i];
        pick_found = 1'b1;
      end
    end
  end

  assign q_interior = (orow != '0) && (LH_W'(orow) < live_h - LH_W'(1)) &&
                      (oc != '0) && (LW_W'(oc) < live_w - LW_W'(1));

  // A stable centre is kept as it is.
  assign replace    = !(k1_d1 > neighbor_threshold) && q_interior && pick_found;
  assign y_new      = replace ? pick_pix : r2_d2;
  assign count_plus = replaced_count + TOTAL_W'(replace);

  always_ff @(posedge clk) begin
    if (rst) begin
      replaced_count <= '0;
    end else if (emit) begin
      replaced_count <= frame_done ? '0 : count_plus;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  pixel_t             out_pixel;
  logic               out_replaced;
  logic               out_last;
  logic [TOTAL_W-1:0] out_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pixel    <= y_new;
      out_replaced <= replace;
      out_last     <= q_last;
      out_total    <= q_last ? count_plus : '0;
    end
  end

  assign m_axis_tdata = OUT_TDATA_W'({out_total, out_pixel});
  assign m_axis_tuser = out_replaced;
  assign m_axis_tlast = out_last;

endmodule

[hdl/ensf_ram.sv]
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ensf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
